// ----- src/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg: shared types, widths and constants for quaternion to euler angles
// fixed-point widths, stage counts and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int COMP_W       = 16;  // quaternion component width
    localparam int ANGLE_W      = 16;  // binary angle width
    localparam int PROD_COMP_W  = 2 * COMP_W;
    localparam int SUM_W        = 35;  // signed quadratic terms
    localparam int NORM_W       = 33;  // squared norm, up to 2^32
    localparam int REM_W        = NORM_W + 1;
    localparam int QUO_W        = 31;  // quotient, up to 2^30
    localparam int ROOT_W       = 31;  // square root, up to 2^30
    localparam int SQ_PROD_W    = 62;  // d * (2^31 - d)
    localparam int SQ_TEST_W    = SQ_PROD_W + 1;
    localparam int CORDIC_STEPS = 40;
    localparam int UNIT_FRAC    = 40;  // cordic angle unit is pi / 2^40
    localparam int XY_W         = UNIT_FRAC + 3;
    localparam int Z_W          = UNIT_FRAC + 3;
    localparam int ROUND_SH     = UNIT_FRAC + 1 - ANGLE_W;
    localparam int QUO_ONE_SH   = 30;

    localparam int LAT_PREP     = 2;
    localparam int LAT_DIV      = QUO_W + 1;
    localparam int LAT_SQRT     = ROOT_W + 1;
    localparam int LAT_ATAN     = CORDIC_STEPS + 4;
    localparam int DLY_PR       = LAT_DIV + LAT_SQRT;
    localparam int DLY_ZERO     = LAT_ATAN + DLY_PR;
    localparam int LAT_TOTAL    = LAT_PREP + DLY_ZERO;

    localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;

    typedef struct packed {
        logic signed [SUM_W-1:0] pitch_y;
        logic signed [SUM_W-1:0] pitch_x;
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] t;
        logic [NORM_W-1:0]       n;
        logic                    zero;
    } qte_prep_t;

    typedef struct packed {
        logic             neg;
        logic [QUO_W-1:0] dq;
    } qte_quot_t;

    typedef struct packed {
        logic              neg;
        logic [QUO_W-1:0]  mag;
        logic [ROOT_W-1:0] root;
    } qte_root_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pitch;
        logic [ANGLE_W-1:0] roll;
    } qte_pr_t;

    // shift-subtract division, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in units of pi / 2^40, from a truncated taylor series in q62
    function automatic logic [UNIT_FRAC-1:0] atan_entry(input int i);
        logic signed [63:0] rad;
        logic [63:0]        term;
        logic [127:0]       prod;
        logic [63:0]        hi;
        int                 e;
        if (i == 0) begin
            return UNIT_FRAC'(64'd1 << (UNIT_FRAC - 2));
        end
        rad = '0;
        for (int k = 0; k < 32; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
                term = udiv64(64'd1 << e, 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    rad = rad - $signed(term);
                end else begin
                    rad = rad + $signed(term);
                end
            end
        end
        prod = {64'd0, rad} * {64'd0, INV_PI_Q64};
        hi   = prod[127:64];
        return UNIT_FRAC'((hi + (64'd1 << 21)) >> 22);
    endfunction

endpackage

`default_nettype wire

// ----- src/qte_prep.sv -----
// ----------------------------------------------------------------------------
// qte_prep: quadratic terms of the quaternion
// ten products in the first stage, norm and atan2 operands in the second
// ----------------------------------------------------------------------------
`default_nettype none

module qte_prep (
    input  wire logic                                aclk,
    input  wire logic                                ce,
    input  wire logic [4*qte_pkg::COMP_W-1:0]        quat,
    output qte_pkg::qte_prep_t                       prep
);

    localparam int CW = qte_pkg::COMP_W;
    localparam int PW = qte_pkg::PROD_COMP_W;
    localparam int SW = qte_pkg::SUM_W;
    localparam int NW = qte_pkg::NORM_W;

    logic signed [CW-1:0] qx, qy, qz, qw;
    assign qx = quat[CW-1:0];
    assign qy = quat[2*CW-1:CW];
    assign qz = quat[3*CW-1:2*CW];
    assign qw = quat[4*CW-1:3*CW];

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, ww_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, xy_reg, wz_reg, wy_reg, xz_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            ww_reg <= qw * qw;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
        end
    end

    qte_pkg::qte_prep_t prep_next, prep_reg;

    always_comb begin
        prep_next.n       = NW'(xx_reg) + NW'(yy_reg) + NW'(zz_reg) + NW'(ww_reg);
        prep_next.pitch_y = (SW'(yz_reg) + SW'(wx_reg)) <<< 1;
        prep_next.pitch_x = SW'(ww_reg) - SW'(xx_reg) - SW'(yy_reg) + SW'(zz_reg);
        prep_next.roll_y  = (SW'(xy_reg) + SW'(wz_reg)) <<< 1;
        prep_next.roll_x  = SW'(ww_reg) + SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg);
        prep_next.t       = (SW'(wy_reg) - SW'(xz_reg)) <<< 1;
        prep_next.zero    = (prep_next.n == '0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

`default_nettype wire

// ----- src/qte_div.sv -----
// ----------------------------------------------------------------------------
// qte_div: pipelined restoring divider for the yaw ratio
// d = ((n - |t|) << 30) / n, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module qte_div (
    input  wire logic                               aclk,
    input  wire logic                               ce,
    input  wire logic signed [qte_pkg::SUM_W-1:0]   t_in,
    input  wire logic [qte_pkg::NORM_W-1:0]         n_in,
    output qte_pkg::qte_quot_t                      quot
);

    localparam int NW = qte_pkg::NORM_W;
    localparam int RW = qte_pkg::REM_W;
    localparam int QW = qte_pkg::QUO_W;

    logic [NW-1:0] at;
    logic [NW-1:0] dnum_next, dnum_reg, n0_reg;
    logic          neg0_reg;

    // |t| never exceeds 2^32
    assign at        = t_in[qte_pkg::SUM_W-1] ? NW'(-t_in) : NW'(t_in);
    assign dnum_next = (at > n_in) ? '0 : n_in - at;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dnum_reg <= dnum_next;
            n0_reg   <= n_in;
            neg0_reg <= t_in[qte_pkg::SUM_W-1];
        end
    end

    logic [RW-1:0] r_reg   [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [NW-1:0] n_reg   [QW];
    logic          neg_reg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [RW-1:0] cand;
        logic [QW-1:0] q_prev;
        logic [NW-1:0] n_prev;
        logic          neg_prev;

        if (g == 0) begin : g_head
            // top quotient bit compares the remainder without doubling
            assign cand     = RW'(dnum_reg);
            assign q_prev   = '0;
            assign n_prev   = n0_reg;
            assign neg_prev = neg0_reg;
        end else begin : g_body
            assign cand     = {r_reg[g-1][RW-2:0], 1'b0};
            assign q_prev   = q_reg[g-1];
            assign n_prev   = n_reg[g-1];
            assign neg_prev = neg_reg[g-1];
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (cand >= RW'(n_prev)) begin
                    r_reg[g] <= cand - RW'(n_prev);
                    q_reg[g] <= {q_prev[QW-2:0], 1'b1};
                end else begin
                    r_reg[g] <= cand;
                    q_reg[g] <= {q_prev[QW-2:0], 1'b0};
                end
                n_reg[g]   <= n_prev;
                neg_reg[g] <= neg_prev;
            end
        end
    end

    assign quot.neg = neg_reg[QW-1];
    assign quot.dq  = q_reg[QW-1];

endmodule

`default_nettype wire

// ----- src/qte_sqrt.sv -----
// ----------------------------------------------------------------------------
// qte_sqrt: cosine term for yaw
// c = floor(sqrt(d * (2^31 - d))), one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt (
    input  wire logic               aclk,
    input  wire logic               ce,
    input  qte_pkg::qte_quot_t      quot,
    output qte_pkg::qte_root_t      root
);

    localparam int QW = qte_pkg::QUO_W;
    localparam int OW = qte_pkg::ROOT_W;
    localparam int PW = qte_pkg::SQ_PROD_W;
    localparam int TW = qte_pkg::SQ_TEST_W;

    logic [QW-1:0]    one_q;
    logic [QW:0]      comp;
    logic [2*QW:0]    prod_full;
    logic [PW-1:0]    prod_reg;
    logic [QW-1:0]    mag0_reg;
    logic             neg0_reg;

    assign one_q     = QW'(1) << qte_pkg::QUO_ONE_SH;
    assign comp      = {one_q, 1'b0} - {1'b0, quot.dq};
    assign prod_full = quot.dq * comp;

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_full[PW-1:0];
            mag0_reg <= one_q - quot.dq;
            neg0_reg <= quot.neg;
        end
    end

    logic [PW-1:0] rem_reg  [OW];
    logic [OW-1:0] rt_reg   [OW];
    logic [QW-1:0] mag_reg  [OW];
    logic          neg_reg  [OW];

    for (genvar g = 0; g < OW; g++) begin : g_step
        localparam int B = OW - 1 - g;
        logic [PW-1:0] rem_prev;
        logic [OW-1:0] rt_prev;
        logic [QW-1:0] mag_prev;
        logic          neg_prev;
        logic [TW-1:0] test;

        if (g == 0) begin : g_head
            assign rem_prev = prod_reg;
            assign rt_prev  = '0;
            assign mag_prev = mag0_reg;
            assign neg_prev = neg0_reg;
        end else begin : g_body
            assign rem_prev = rem_reg[g-1];
            assign rt_prev  = rt_reg[g-1];
            assign mag_prev = mag_reg[g-1];
            assign neg_prev = neg_reg[g-1];
        end

        // (r + 2^b)^2 - r^2
        assign test = (TW'(rt_prev) << (B + 1)) + (TW'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (TW'(rem_prev) >= test) begin
                    rem_reg[g] <= PW'(TW'(rem_prev) - test);
                    rt_reg[g]  <= rt_prev | (OW'(1) << B);
                end else begin
                    rem_reg[g] <= rem_prev;
                    rt_reg[g]  <= rt_prev;
                end
                mag_reg[g] <= mag_prev;
                neg_reg[g] <= neg_prev;
            end
        end
    end

    assign root.neg  = neg_reg[OW-1];
    assign root.mag  = mag_reg[OW-1];
    assign root.root = rt_reg[OW-1];

endmodule

`default_nettype wire

// ----- src/qte_atan.sv -----
// ----------------------------------------------------------------------------
// qte_atan: pipelined atan2 by cordic vectoring
// magnitude, two normalize stages, 40 rotation stages, quadrant fix and rounding
// ----------------------------------------------------------------------------
`default_nettype none

module qte_atan (
    input  wire logic                               aclk,
    input  wire logic                               ce,
    input  wire logic signed [qte_pkg::SUM_W-1:0]   y_in,
    input  wire logic signed [qte_pkg::SUM_W-1:0]   x_in,
    output logic [qte_pkg::ANGLE_W-1:0]             angle
);

    localparam int SW = qte_pkg::SUM_W;
    localparam int UF = qte_pkg::UNIT_FRAC;
    localparam int XW = qte_pkg::XY_W;
    localparam int ZW = qte_pkg::Z_W;
    localparam int NS = qte_pkg::CORDIC_STEPS;

    // quadrant flags ride along the whole pipe
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zero;
    } quad_t;

    logic [UF-1:0] ax0_reg, ay0_reg, ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    quad_t         qd0_reg, qd1_reg, qd2_reg;
    logic [UF-1:0] ax1_next, ay1_next, ax2_next, ay2_next;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax0_reg      <= UF'(x_in[SW-1] ? -x_in : x_in);
            ay0_reg      <= UF'(y_in[SW-1] ? -y_in : y_in);
            qd0_reg.xneg <= x_in[SW-1];
            qd0_reg.yneg <= y_in[SW-1];
            qd0_reg.zero <= (x_in == '0) && (y_in == '0);
        end
    end

    // left-normalize until the larger magnitude reaches 2^39
    always_comb begin
        ax1_next = ax0_reg;
        ay1_next = ay0_reg;
        for (int k = 32; k >= 8; k = k / 2) begin
            if (((ax1_next | ay1_next) >> (UF - k)) == '0) begin
                ax1_next = ax1_next << k;
                ay1_next = ay1_next << k;
            end
        end
        ax2_next = ax1_reg;
        ay2_next = ay1_reg;
        for (int k = 4; k >= 1; k = k / 2) begin
            if (((ax2_next | ay2_next) >> (UF - k)) == '0) begin
                ax2_next = ax2_next << k;
                ay2_next = ay2_next << k;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax1_reg <= ax1_next;
            ay1_reg <= ay1_next;
            qd1_reg <= qd0_reg;
            ax2_reg <= ax2_next;
            ay2_reg <= ay2_next;
            qd2_reg <= qd1_reg;
        end
    end

    logic signed [XW-1:0] cx_reg [NS];
    logic signed [XW-1:0] cy_reg [NS];
    logic signed [ZW-1:0] cz_reg [NS];
    quad_t                qd_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_rot
        localparam logic [UF-1:0] TAB = qte_pkg::atan_entry(i);
        logic signed [XW-1:0] cx_prev, cy_prev, dx, dy;
        logic signed [ZW-1:0] cz_prev, tz;
        quad_t                qd_prev;

        if (i == 0) begin : g_head
            assign cx_prev = $signed(XW'(ax2_reg));
            assign cy_prev = $signed(XW'(ay2_reg));
            assign cz_prev = '0;
            assign qd_prev = qd2_reg;
        end else begin : g_body
            assign cx_prev = cx_reg[i-1];
            assign cy_prev = cy_reg[i-1];
            assign cz_prev = cz_reg[i-1];
            assign qd_prev = qd_reg[i-1];
        end

        assign dx = cy_prev >>> i;
        assign dy = cx_prev >>> i;
        assign tz = $signed(ZW'(TAB));

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!cy_prev[XW-1]) begin
                    cx_reg[i] <= cx_prev + dx;
                    cy_reg[i] <= cy_prev - dy;
                    cz_reg[i] <= cz_prev + tz;
                end else begin
                    cx_reg[i] <= cx_prev - dx;
                    cy_reg[i] <= cy_prev + dy;
                    cz_reg[i] <= cz_prev - tz;
                end
                qd_reg[i] <= qd_prev;
            end
        end
    end

    logic signed [ZW-1:0]  zq, zs, zr;
    logic [qte_pkg::ANGLE_W-1:0] angle_next, angle_reg;

    always_comb begin
        zq = qd_reg[NS-1].xneg ? ($signed(ZW'(1) << UF) - cz_reg[NS-1]) : cz_reg[NS-1];
        zs = qd_reg[NS-1].yneg ? -zq : zq;
        zr = (zs + $signed(ZW'(1) << (qte_pkg::ROUND_SH - 1))) >>> qte_pkg::ROUND_SH;
        angle_next = qd_reg[NS-1].zero ? '0 : zr[qte_pkg::ANGLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

// ----- src/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: orientation quaternion to pitch, yaw and roll
// pitch and roll by cordic atan2, yaw by asin through divide, sqrt and atan2
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata = quat_x, quat_y, quat_z, quat_w
//  m_       out  m_tvalid/m_tready  m_tdata = pitch, yaw, roll; m_tuser = zero_input
//
//  one quaternion per cycle unless a stalled output freezes the pipe; the
//  path from the input transfer to the result showing on m_tvalid is set by
//  the yaw path: 2 quadratic-term stages, 32 divider stages, 32 square root
//  stages, 44 cordic stages and the output register
//  aresetn is synchronous and clears only the valid bits
//  a stalled output freezes the pipe only once its last stage holds an
//  item; bubbles still close up and new transfers are taken meanwhile
//
`default_nettype none

module quaternion_to_euler_angles (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,   // pitch_angle, yaw_angle, roll_angle
    output logic [0:0]         m_tuser    // zero_input
);

    localparam int LAT = qte_pkg::LAT_TOTAL;
    localparam int AW  = qte_pkg::ANGLE_W;
    localparam int SW  = qte_pkg::SUM_W;

    // pipeline advance: hold only when the last stage is full and cannot drain
    logic             ce;
    logic             out_load;
    logic [LAT-1:0]   vld_reg, vld_next;

    assign out_load = !m_tvalid || m_tready;
    assign ce       = !vld_reg[LAT-1] || out_load;
    assign s_tready = ce;

    assign vld_next = ce ? {vld_reg[LAT-2:0], s_tvalid} : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // quadratic terms
    qte_pkg::qte_prep_t prep;

    qte_prep u_prep (
        .aclk (aclk),
        .ce   (ce),
        .quat (s_tdata),
        .prep (prep)
    );

    // pitch and roll finish early and wait in a delay line
    logic [AW-1:0] pitch_raw, roll_raw;

    qte_atan u_atan_pitch (
        .aclk  (aclk),
        .ce    (ce),
        .y_in  (prep.pitch_y),
        .x_in  (prep.pitch_x),
        .angle (pitch_raw)
    );

    qte_atan u_atan_roll (
        .aclk  (aclk),
        .ce    (ce),
        .y_in  (prep.roll_y),
        .x_in  (prep.roll_x),
        .angle (roll_raw)
    );

    // yaw: ratio, cosine term, then atan2
    qte_pkg::qte_quot_t quot;
    qte_pkg::qte_root_t root;

    qte_div u_div (
        .aclk (aclk),
        .ce   (ce),
        .t_in (prep.t),
        .n_in (prep.n),
        .quot (quot)
    );

    qte_sqrt u_sqrt (
        .aclk (aclk),
        .ce   (ce),
        .quot (quot),
        .root (root)
    );

    logic signed [SW-1:0] yaw_y, yaw_x;
    logic [AW-1:0]        yaw_raw;

    assign yaw_y = root.neg ? -$signed(SW'(root.mag)) : $signed(SW'(root.mag));
    assign yaw_x = $signed(SW'(root.root));

    qte_atan u_atan_yaw (
        .aclk  (aclk),
        .ce    (ce),
        .y_in  (yaw_y),
        .x_in  (yaw_x),
        .angle (yaw_raw)
    );

    // alignment delay lines
    qte_pkg::qte_pr_t pr_dly_reg   [qte_pkg::DLY_PR];
    logic             zero_dly_reg [qte_pkg::DLY_ZERO];

    always_ff @(posedge aclk) begin
        if (ce) begin
            pr_dly_reg[0].pitch <= pitch_raw;
            pr_dly_reg[0].roll  <= roll_raw;
            for (int k = 1; k < qte_pkg::DLY_PR; k++) begin
                pr_dly_reg[k] <= pr_dly_reg[k-1];
            end
            zero_dly_reg[0] <= prep.zero;
            for (int k = 1; k < qte_pkg::DLY_ZERO; k++) begin
                zero_dly_reg[k] <= zero_dly_reg[k-1];
            end
        end
    end

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    logic [47:0]   m_tdata_reg, m_tdata_next;
    logic          m_zero_reg, m_zero_next;
    logic          zero_last;

    assign zero_last = zero_dly_reg[qte_pkg::DLY_ZERO-1];

    always_comb begin
        m_tvalid_next = out_load ? vld_reg[LAT-1] : m_tvalid_reg;
        m_zero_next   = zero_last;
        if (zero_last) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {pr_dly_reg[qte_pkg::DLY_PR-1].roll, yaw_raw,
                            pr_dly_reg[qte_pkg::DLY_PR-1].pitch};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && vld_reg[LAT-1]) begin
            m_tdata_reg <= m_tdata_next;
            m_zero_reg  <= m_zero_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_zero_reg;

endmodule

`default_nettype wire

// ----- src/qte_checker.sv -----
// ----------------------------------------------------------------------------
// qte_checker: port-level assertions for quaternion_to_euler_angles
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module qte_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_tready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [47:0]   m_tdata,
    input wire logic [0:0]    m_tuser
);

    logic signed [15:0] yaw;
    assign yaw = m_tdata[31:16];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // zero quaternion gives zero angles
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero input with nonzero angles");

    // yaw stays within plus or minus half pi
    a_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (yaw >= -16'sd16384) && (yaw <= 16'sd16384))
        else $error("yaw out of range");

    // an empty output never blocks the input
    a_ready: assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

`default_nettype wire

// ----- tb/sv/quaternion_to_euler_angles_test.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_test: self-checking bench for quaternion to euler
// drives quaternions with bursty valid and checks each result transfer
// against a bit-exact cordic, divide and square root predictor
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [qte_pkg::ANGLE_W-1:0] pitch;
        logic [qte_pkg::ANGLE_W-1:0] yaw;
        logic [qte_pkg::ANGLE_W-1:0] roll;
        logic                        zero;
    } angles_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pitch_angle, yaw_angle, roll_angle
    logic [0:0]  m_tuser;   // zero_input

    angles_t pending_angles[$];
    longint  atan_units[qte_pkg::CORDIC_STEPS];
    int      error_count;
    int      burst_left;
    int      stall_mode;

    quaternion_to_euler_angles dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // arctangent table in units of pi / 2^40
    task automatic fill_atan_units();
        longint      rad;
        logic [63:0] term;
        logic [127:0] prod;
        int          e;
        atan_units[0] = 64'd1 << (qte_pkg::UNIT_FRAC - 2);
        for (int i = 1; i < qte_pkg::CORDIC_STEPS; i++) begin
            rad = 0;
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if (k & 1) rad = rad - longint'(term);
                    else       rad = rad + longint'(term);
                end
            end
            prod = {64'd0, rad} * {64'd0, qte_pkg::INV_PI_Q64};
            atan_units[i] = longint'((prod[127:64] + (64'd1 << 21)) >> 22);
        end
    endtask

    function automatic longint vector_angle(longint yv, longint xv);
        logic [63:0] ax;
        logic [63:0] ay;
        longint      cx;
        longint      cy;
        longint      acc;
        longint      dx;
        longint      dy;
        if (xv == 0 && yv == 0) return 0;
        ax  = xv < 0 ? 64'(-xv) : 64'(xv);
        ay  = yv < 0 ? 64'(-yv) : 64'(yv);
        acc = 0;
        while ((ax | ay) >= (64'd1 << qte_pkg::UNIT_FRAC)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        while ((ax | ay) < (64'd1 << (qte_pkg::UNIT_FRAC - 1))) begin
            ax = ax << 1;
            ay = ay << 1;
        end
        cx = longint'(ax);
        cy = longint'(ay);
        for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx  = cx + dx;
                cy  = cy - dy;
                acc = acc + atan_units[i];
            end else begin
                cx  = cx - dx;
                cy  = cy + dy;
                acc = acc - atan_units[i];
            end
        end
        if (xv < 0) acc = (longint'(1) << qte_pkg::UNIT_FRAC) - acc;
        if (yv < 0) acc = -acc;
        return acc;
    endfunction

    // round units of pi / 2^40 to a binary angle, pi wraps to -pi
    function automatic logic [qte_pkg::ANGLE_W-1:0] binary_angle(longint units);
        longint r;
        r = (units + (longint'(1) << (qte_pkg::ROUND_SH - 1))) >>> qte_pkg::ROUND_SH;
        return r[qte_pkg::ANGLE_W-1:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic angles_t euler_from_quat(logic [63:0] q);
        longint      x, y, z, w, n, t;
        logic [63:0] at, nu, dnum, dq, mag, c;
        logic [63:0] one;
        angles_t     a;
        one = 64'd1 << qte_pkg::QUO_ONE_SH;
        x = longint'($signed(q[15:0]));
        y = longint'($signed(q[31:16]));
        z = longint'($signed(q[47:32]));
        w = longint'($signed(q[63:48]));
        n = x * x + y * y + z * z + w * w;
        a = '0;
        if (n == 0) begin
            a.zero = 1'b1;
            return a;
        end
        a.pitch = binary_angle(vector_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z));
        a.roll  = binary_angle(vector_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
        // yaw: asin via d = 1 - |t|/n, then atan2(1-d, sqrt(d(2-d)))
        t  = 2 * (w * y - x * z);
        at = t < 0 ? 64'(-t) : 64'(t);
        nu = 64'(n);
        while ((nu >> 33) != 0) begin
            nu = nu >> 1;
            at = at >> 1;
        end
        dnum = at > nu ? 64'd0 : nu - at;
        dq   = (dnum << 30) / nu;
        if (dq > one) dq = one;
        mag = one - dq;
        c   = floor_sqrt(dq * ((one << 1) - dq));
        a.yaw = binary_angle(vector_angle(t < 0 ? -longint'(mag) : longint'(mag), longint'(c)));
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [qte_pkg::ANGLE_W-1:0] got,
                                   logic [qte_pkg::ANGLE_W-1:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // result transfer checker
    always @(posedge aclk) begin
        angles_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_angles.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[15:0], '0);
            end else begin
                want = pending_angles.pop_front();
                if (m_tdata[15:0] !== want.pitch) report_mismatch("pitch", m_tdata[15:0], want.pitch);
                if (m_tdata[31:16] !== want.yaw) report_mismatch("yaw", m_tdata[31:16], want.yaw);
                if (m_tdata[47:32] !== want.roll) report_mismatch("roll", m_tdata[47:32], want.roll);
                if (m_tuser[0] !== want.zero) report_mismatch("zero", 16'(m_tuser), 16'(want.zero));
            end
        end
    end

    // receiver stalls: stretches of always ready, light and heavy back-pressure
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 3) != 0;
            default: m_tready <= $urandom_range(0, 3) == 0;
        endcase
    end

    // one input transfer, with bursts of random length and random gaps
    task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {w, z, y, x};
        do @(posedge aclk); while (!s_tready);
        pending_angles.push_back(euler_from_quat({w, z, y, x}));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_angles.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // zero norm
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);   // identity
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);   // pitch of pi
        send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000);   // roll of pi
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);   // all minimum
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);   // all maximum
        send_quat(16'h0000, 16'h5a82, 16'h0000, 16'h5a82);   // yaw +90, gimbal lock
        send_quat(16'h0000, 16'ha57e, 16'h0000, 16'h5a82);   // yaw -90
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);   // tiny
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'hffff);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_quat(16'hc000, 16'h4000, 16'hc000, 16'h4000);
        send_quat(16'h0000, 16'h0001, 16'h0000, 16'h0001);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
    endtask

    function automatic logic [15:0] scaled_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
            2: return $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) - 16'd2 : 16'd0;
            default: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                                 : 16'h8000 + 16'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_random(int count);
        int mode;
        logic [15:0] c[4];
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 9);
            for (int j = 0; j < 4; j++) begin
                c[j] = scaled_comp(mode < 5 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : $urandom_range(0, 3));
                if (mode == 9 && $urandom_range(0, 1)) c[j] = 16'd0;
            end
            // x = +-z, y = +-w with random signs; for x = -z*s, y = w*s, wy - xz is large (yaw near +-90)
            if (mode == 4) begin
                c[0] = $urandom_range(0, 1) ? c[2] : -c[2];
                c[1] = $urandom_range(0, 1) ? c[3] : -c[3];
                if ($urandom_range(0, 1)) c[0] = c[0] + 16'($urandom_range(0, 3));
            end
            send_quat(c[0], c[1], c[2], c[3]);
        end
    endtask

    initial begin
        #2ms;
        $display("quaternion_to_euler_angles regression: fail");
        $finish;
    end

    initial begin
        error_count = 0;
        burst_left  = 0;
        stall_mode  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        fill_atan_units();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        wait_drained();
        test_random(300);
        wait_drained();
        test_random(300);
        wait_drained();
        repeat (qte_pkg::LAT_TOTAL + 20) @(posedge aclk);
        if (error_count == 0) begin
            $display("quaternion_to_euler_angles regression: pass");
        end else begin
            $display("quaternion_to_euler_angles regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
